// ===== hw/rtl/afd_pkg.sv =====
// package for the audio frame deframer
// shared constants, status codes, register indexes and the result record
// no dependencies
`default_nettype none

package afd_pkg;

  localparam int HEADER_LENGTH = 18;
  localparam int POS_W         = 17;
  localparam int LEN_W         = 16;
  localparam int CNT_W         = 15;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};

  // header byte positions
  localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_STREAM   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_RESERVED = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(16);
  localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(17);
  localparam logic [POS_W-1:0] POS_HDR      = POS_W'(HEADER_LENGTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM      = 2'd2;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd8192;
  localparam logic [7:0]       VERSION_RST     = 8'd1;
  localparam logic [7:0]       STREAM_RST      = 8'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MAGIC    = 3'd1,
    ST_HDR_FLD  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  typedef struct packed {
    logic              sample_valid;
    logic [15:0]       sample_value;
    logic              frame_done;
    status_t           frame_status;
    logic [CNT_W-1:0]  sample_count;
  } res_t;

  // magic "SFA1"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h53;
      2'd1:    b = 8'h46;
      2'd2:    b = 8'h41;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/afd_core.sv =====
// per-byte frame parser: position counter, header checks, sample pairing
// and the end-of-frame status; depends on afd_pkg
`default_nettype none

module afd_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic [7:0]                    frame_byte,
  input  wire logic                          last_byte,
  input  wire logic [afd_pkg::LEN_W-1:0]     max_payload,
  input  wire logic [7:0]                    exp_version,
  input  wire logic [7:0]                    exp_stream,
  output logic                               push,
  output afd_pkg::res_t                      res
);

  logic [afd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [afd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [7:0]                low_r, low_nxt;
  afd_pkg::status_t          fault_r, fault_nxt;

  logic                      fault_hit;
  afd_pkg::status_t          fault_code;
  logic                      have_sample;
  afd_pkg::status_t          status;
  logic [afd_pkg::POS_W-1:0] expect_last_pos;

  always_comb begin
    fault_hit   = 1'b0;
    fault_code  = afd_pkg::ST_OK;
    have_sample = 1'b0;
    len_nxt     = len_r;
    low_nxt     = low_r;
    if (pos_r < afd_pkg::POS_VERSION) begin
      fault_hit  = frame_byte != afd_pkg::magic_byte(pos_r[1:0]);
      fault_code = afd_pkg::ST_MAGIC;
    end else if (pos_r == afd_pkg::POS_VERSION) begin
      fault_hit  = frame_byte != exp_version;
      fault_code = afd_pkg::ST_HDR_FLD;
    end else if (pos_r == afd_pkg::POS_STREAM) begin
      fault_hit  = frame_byte != exp_stream;
      fault_code = afd_pkg::ST_HDR_FLD;
    end else if (pos_r == afd_pkg::POS_RESERVED) begin
      fault_hit  = frame_byte != 8'd0;
      fault_code = afd_pkg::ST_HDR_FLD;
    end else if (pos_r == afd_pkg::POS_LEN_HI) begin
      len_nxt = {frame_byte, 8'd0};
    end else if (pos_r == afd_pkg::POS_LEN_LO) begin
      len_nxt = {len_r[15:8], frame_byte};
    end else if (pos_r >= afd_pkg::POS_HDR && pos_r != afd_pkg::POS_TOP) begin
      if (!pos_r[0]) begin
        low_nxt = frame_byte;
      end else begin
        have_sample = 1'b1;
      end
    end
    // only the first header fault counts
    fault_nxt = (fault_r == afd_pkg::ST_OK && fault_hit) ? fault_code : fault_r;
  end

  // last byte sits at header length plus payload length minus one
  assign expect_last_pos = {1'b0, len_nxt} + afd_pkg::POS_W'(afd_pkg::HEADER_LENGTH - 1);

  always_comb begin
    if (pos_r < afd_pkg::POS_LEN_LO) begin
      status = afd_pkg::ST_MAGIC;
    end else if (fault_nxt != afd_pkg::ST_OK) begin
      status = fault_nxt;
    end else if (len_nxt == '0 || len_nxt > max_payload) begin
      status = afd_pkg::ST_BAD_LEN;
    end else if (pos_r == afd_pkg::POS_TOP || pos_r != expect_last_pos) begin
      status = afd_pkg::ST_MISMATCH;
    end else if (len_nxt[0]) begin
      status = afd_pkg::ST_BAD_LEN;
    end else begin
      status = afd_pkg::ST_OK;
    end
  end

  always_comb begin
    push                  = acc && (have_sample || last_byte);
    res.sample_valid      = have_sample;
    res.sample_value      = have_sample ? {frame_byte, low_r} : 16'd0;
    res.frame_done        = last_byte;
    res.frame_status      = last_byte ? status : afd_pkg::ST_OK;
    res.sample_count      = (last_byte && status == afd_pkg::ST_OK) ?
                            len_nxt[afd_pkg::LEN_W-1:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      low_r   <= '0;
      fault_r <= afd_pkg::ST_OK;
    end else if (acc) begin
      if (last_byte) begin
        pos_r   <= '0;
        len_r   <= '0;
        low_r   <= '0;
        fault_r <= afd_pkg::ST_OK;
      end else begin
        pos_r   <= (pos_r == afd_pkg::POS_TOP) ? pos_r : pos_r + 1'b1;
        len_r   <= len_nxt;
        low_r   <= low_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_byte |=> pos_r == '0 && fault_r == afd_pkg::ST_OK)
    else $error("frame state not cleared after last byte");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !last_byte && pos_r != afd_pkg::POS_TOP |=> pos_r == $past(pos_r) + 1'b1)
    else $error("byte position did not advance");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.frame_status != afd_pkg::ST_OK |-> res.frame_done)
    else $error("status reported without frame end");

endmodule

`default_nettype wire

// ===== hw/rtl/afd_out_buf.sv =====
// result register with one skid entry so the parser keeps taking bytes
// while a result waits; depends on afd_pkg
`default_nettype none

module afd_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  afd_pkg::res_t      din,
  output logic               full,
  input  wire logic          out_stall,
  output logic               out_valid,
  output afd_pkg::res_t      dout
);

  logic          out_valid_r, skid_valid_r;
  afd_pkg::res_t out_r, skid_r;
  logic          take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_r <= skid_valid_r ? skid_r : din;
    end else if (push) begin
      skid_r <= din;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("transaction pushed into full result buffer");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== hw/rtl/audio_frame_deframer.sv =====
// audio frame deframer, top level
// holds the configuration registers; uses afd_pkg, afd_core, afd_out_buf
//
// usage:
//   input channel: one message byte per transaction (in_frame_byte), with
//   in_last_byte set on the final byte; a transaction completes when in_valid
//   is high and in_stall is low.
//   result channel: out_valid/out_stall; a result appears for each completed
//   sample and for the last byte of a message (both can share one result).
//   samples are tentative: drop them downstream if the frame status is not 0.
//   config: cfg_we writes cfg_wdata into register cfg_index (0 max payload,
//   1 expected version, 2 expected stream); write only while idle.
// throughput: one byte per cycle while in_stall is low; the parser handles each
//   byte combinationally between the frame state registers and the result buffer.
// results: each is registered in the output register, or in the skid if held.
// stall: a two-entry result buffer (output register plus skid) absorbs one
//   extra result; in_stall rises only while both entries are occupied.
// reset: frame state clears, the result buffer empties and the configuration
//   returns to max payload 8192, version 1, stream 2.
`default_nettype none

module audio_frame_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_frame_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_sample_valid,
  output logic signed [15:0]                   out_sample_value,
  output logic                                 out_frame_done,
  output logic [2:0]                           out_frame_status,
  output logic [afd_pkg::CNT_W-1:0]            out_sample_count,
  input  wire logic                            cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [afd_pkg::LEN_W-1:0] max_payload_r;
  logic [7:0]                version_r;
  logic [7:0]                stream_r;

  logic          acc;
  logic          push;
  logic          full;
  afd_pkg::res_t res, dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= afd_pkg::MAX_PAYLOAD_RST;
      version_r     <= afd_pkg::VERSION_RST;
      stream_r      <= afd_pkg::STREAM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afd_pkg::CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata[afd_pkg::LEN_W-1:0];
        afd_pkg::CFG_VERSION:     version_r     <= cfg_wdata[7:0];
        afd_pkg::CFG_STREAM:      stream_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign acc      = in_valid && !full;

  afd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .frame_byte  (in_frame_byte),
    .last_byte   (in_last_byte),
    .max_payload (max_payload_r),
    .exp_version (version_r),
    .exp_stream  (stream_r),
    .push        (push),
    .res         (res)
  );

  afd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (res),
    .full      (full),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (dout)
  );

  assign out_sample_valid = dout.sample_valid;
  assign out_sample_value = dout.sample_value;
  assign out_frame_done   = dout.frame_done;
  assign out_frame_status = dout.frame_status;
  assign out_sample_count = dout.sample_count;

endmodule

`default_nettype wire
